FILE: rtl/core/skt_pkg.sv
`timescale 1ns / 1ps
package skt_pkg;

  localparam int CMD_W       = 3;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 47;
  localparam int STATUS_W    = 3;
  localparam int IDX_OUT_W   = 7;
  localparam int TABLE_DEPTH_DEFAULT = 128;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 3'd0,
    CMD_ADD   = 3'd1,
    CMD_SUB   = 3'd2,
    CMD_READ  = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NOT_FOUND    = 3'd1,
    ST_INSUFFICIENT = 3'd2,
    ST_FULL         = 3'd3,
    ST_SATURATED    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_COMPARE,
    S_VALUE,
    S_FINISH
  } state_t;

endpackage

FILE: rtl/core/skt_ram.sv
`timescale 1ns / 1ps
module skt_ram import skt_pkg::*; #(
  parameter int WIDTH  = KEY_W,
  parameter int DEPTH  = TABLE_DEPTH_DEFAULT,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/core/sorted_key_table_balance_update_unit.sv
`timescale 1ns / 1ps
// Sorted key table with balance updates. Each input transaction yields exactly one
// result transaction. Load, clear and unused commands go from the execute state to
// the finish state and then to the output register. Add, subtract and read run a
// binary search over the loaded entries, each probe issuing the address and then
// comparing against the registered key RAM output, followed by a value RAM read and
// read-modify-write. The finish state waits until the output register is free
// (empty, or being taken with out_ready). One transaction is in flight at a time; the
// next is accepted while the previous result waits in the output register.
// Keys must be loaded in ascending order for lookups to be meaningful.
module sorted_key_table_balance_update_unit import skt_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [KEY_W-1:0]     key,
  input  logic [VAL_W-1:0]     amount,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  status,
  output logic [IDX_OUT_W-1:0] found_index,
  output logic [VAL_W-1:0]     value_after
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);
  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  state_t state, state_next;

  cmd_t             cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] amount_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi_x;
  logic [IDX_W-1:0] mid_q;

  status_t          res_status;
  logic [IDX_OUT_W-1:0] res_index;
  logic [VAL_W-1:0] res_value;

  logic             key_we;
  logic [IDX_W-1:0] key_addr;
  logic [KEY_W-1:0] key_rdata;
  logic             val_we;
  logic [IDX_W-1:0] val_addr;
  logic [VAL_W-1:0] val_wdata;
  logic [VAL_W-1:0] val_rdata;

  logic [CNT_W:0]   mid_sum;
  logic [IDX_W-1:0] mid;
  logic             range_open;
  logic             full;
  logic [VAL_W:0]   sum;
  logic             sat;
  logic             sub_ok;
  logic [IDX_W+IDX_OUT_W-1:0] load_idx_ext;
  logic [IDX_W+IDX_OUT_W-1:0] mid_idx_ext;
  logic             out_free;

  skt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH),
    .ADDR_W(IDX_W)
  ) u_key_ram (
    .clk  (clk),
    .we   (key_we),
    .addr (key_addr),
    .wdata(key_q),
    .rdata(key_rdata)
  );

  skt_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_DEPTH),
    .ADDR_W(IDX_W)
  ) u_val_ram (
    .clk  (clk),
    .we   (val_we),
    .addr (val_addr),
    .wdata(val_wdata),
    .rdata(val_rdata)
  );

  assign mid_sum      = {1'b0, lo} + {1'b0, hi_x} - (CNT_W + 1)'(1);
  assign mid          = mid_sum[IDX_W:1];
  assign range_open   = lo < hi_x;
  assign full         = count == FULL_COUNT;
  assign sum          = {1'b0, val_rdata} + {1'b0, amount_q};
  assign sat          = sum[VAL_W];
  assign sub_ok       = val_rdata >= amount_q;
  assign load_idx_ext = {{IDX_OUT_W{1'b0}}, count[IDX_W-1:0]};
  assign mid_idx_ext  = {{IDX_OUT_W{1'b0}}, mid_q};
  assign out_free     = !out_valid || out_ready;
  assign in_ready     = state == S_IDLE;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (cmd_q)
          CMD_ADD, CMD_SUB, CMD_READ: state_next = S_SEARCH;
          default:                    state_next = S_FINISH;
        endcase
      end
      S_SEARCH: begin
        state_next = range_open ? S_COMPARE : S_FINISH;
      end
      S_COMPARE: begin
        state_next = (key_rdata == key_q) ? S_VALUE : S_SEARCH;
      end
      S_VALUE: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    key_we    = 1'b0;
    key_addr  = mid;
    val_we    = 1'b0;
    val_addr  = mid_q;
    val_wdata = amount_q;
    unique case (state)
      S_EXEC: begin
        key_addr = count[IDX_W-1:0];
        val_addr = count[IDX_W-1:0];
        if (cmd_q == CMD_LOAD && !full) begin
          key_we = 1'b1;
          val_we = 1'b1;
        end
      end
      S_VALUE: begin
        if (cmd_q == CMD_ADD) begin
          val_we    = 1'b1;
          val_wdata = sat ? VAL_MAX : sum[VAL_W-1:0];
        end else if (cmd_q == CMD_SUB && sub_ok) begin
          val_we    = 1'b1;
          val_wdata = val_rdata - amount_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_EXEC) begin
        if (cmd_q == CMD_LOAD && !full) begin
          count <= count + CNT_W'(1);
        end else if (cmd_q == CMD_CLEAR) begin
          count <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd_q    <= cmd_t'(cmd);
      key_q    <= key;
      amount_q <= amount;
      lo       <= '0;
      hi_x     <= count;
    end
    unique case (state)
      S_EXEC: begin
        if (cmd_q == CMD_LOAD && full) begin
          res_status <= ST_FULL;
        end else begin
          res_status <= ST_OK;
        end
        if (cmd_q == CMD_LOAD && !full) begin
          res_index <= load_idx_ext[IDX_OUT_W-1:0];
          res_value <= amount_q;
        end else begin
          res_index <= '0;
          res_value <= '0;
        end
      end
      S_SEARCH: begin
        mid_q <= mid;
        if (!range_open) begin
          res_status <= ST_NOT_FOUND;
        end
      end
      S_COMPARE: begin
        if (key_rdata < key_q) begin
          lo <= CNT_W'(mid_q) + CNT_W'(1);
        end else if (key_rdata != key_q) begin
          hi_x <= CNT_W'(mid_q);
        end
      end
      S_VALUE: begin
        res_index <= mid_idx_ext[IDX_OUT_W-1:0];
        if (cmd_q == CMD_ADD) begin
          res_value <= sat ? VAL_MAX : sum[VAL_W-1:0];
          if (sat) begin
            res_status <= ST_SATURATED;
          end
        end else if (cmd_q == CMD_SUB && sub_ok) begin
          res_value <= val_rdata - amount_q;
        end else begin
          res_value <= val_rdata;
          if (cmd_q == CMD_SUB) begin
            res_status <= ST_INSUFFICIENT;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          status      <= res_status;
          found_index <= res_index;
          value_after <= res_value;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: dv/tb_sorted_key_table_balance_update_unit.sv
`timescale 1ns / 1ps
module tb_sorted_key_table_balance_update_unit;
  import skt_pkg::*;

  localparam int TABLE_DEPTH = TABLE_DEPTH_DEFAULT;
  localparam int QUIET_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST = 3'd7;
  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] amount;
    logic after_drain;
  } account_cmd_t;

  typedef struct packed {
    status_t status;
    logic [IDX_OUT_W-1:0] idx;
    logic [VAL_W-1:0] val;
  } ledger_reply_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] cmd = '0;
  logic [KEY_W-1:0] key = '0;
  logic [VAL_W-1:0] amount = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [IDX_OUT_W-1:0] found_index;
  logic [VAL_W-1:0] value_after;

  account_cmd_t account_cmds[$];
  ledger_reply_t ledger_replies[$];

  logic [KEY_W-1:0] ledger_key[TABLE_DEPTH];
  logic [VAL_W-1:0] ledger_val[TABLE_DEPTH];
  int ledger_count = 0;

  logic [KEY_W-1:0] loaded_keys[$];
  int loaded_count = 0;
  int queued_total = 0;
  bit drain_next = 1'b0;

  int n_taken = 0;
  int n_replied = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  bit in_taken = 1'b0;
  logic steady;

  assign steady = (n_taken >= 250) && (n_taken < 370);

  sorted_key_table_balance_update_unit #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .key(key),
    .amount(amount),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .found_index(found_index),
    .value_after(value_after)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic ledger_apply(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                              input logic [VAL_W-1:0] a, output ledger_reply_t r);
    int lo;
    int hi;
    int mid;
    int pos;
    logic [VAL_W:0] sum;
    r.status = ST_OK;
    r.idx = '0;
    r.val = '0;
    case (c)
      CMD_LOAD: begin
        if (ledger_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ledger_key[ledger_count] = k;
          ledger_val[ledger_count] = a;
          r.idx = IDX_OUT_W'(ledger_count);
          r.val = a;
          ledger_count++;
        end
      end
      CMD_ADD, CMD_SUB, CMD_READ: begin
        lo = 0;
        hi = ledger_count - 1;
        pos = -1;
        while (lo <= hi && pos < 0) begin
          mid = (lo + hi) / 2;
          if (ledger_key[mid] == k) pos = mid;
          else if (ledger_key[mid] < k) lo = mid + 1;
          else hi = mid - 1;
        end
        if (pos < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          if (c == CMD_ADD) begin
            sum = {1'b0, ledger_val[pos]} + {1'b0, a};
            if (sum[VAL_W]) begin
              ledger_val[pos] = VAL_MAX;
              r.status = ST_SATURATED;
            end else begin
              ledger_val[pos] = sum[VAL_W-1:0];
            end
          end else if (c == CMD_SUB) begin
            if (ledger_val[pos] >= a) ledger_val[pos] = ledger_val[pos] - a;
            else r.status = ST_INSUFFICIENT;
          end
          r.idx = IDX_OUT_W'(pos);
          r.val = ledger_val[pos];
        end
      end
      CMD_CLEAR: ledger_count = 0;
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch in %s at result %0d: got %0h, want %0h", field, n_replied, got, want);
    mismatches++;
  endtask

  task automatic queue_cmd(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                           input logic [VAL_W-1:0] a);
    account_cmd_t t;
    t.cmd = c;
    t.key = k;
    t.amount = a;
    t.after_drain = drain_next;
    drain_next = 1'b0;
    account_cmds.push_back(t);
    queued_total++;
    if (c == CMD_LOAD && loaded_count < TABLE_DEPTH) begin
      loaded_keys.push_back(k);
      loaded_count++;
    end else if (c == CMD_CLEAR) begin
      loaded_keys.delete();
      loaded_count = 0;
    end
  endtask

  function automatic logic [VAL_W-1:0] pick_amount();
    case ($urandom_range(3))
      0: return VAL_W'($urandom_range(1000));
      1: return VAL_MAX - VAL_W'($urandom_range(1000));
      default: return VAL_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if (loaded_keys.size() != 0 && $urandom_range(9) < 8)
      return loaded_keys[$urandom_range(loaded_keys.size() - 1)];
    return $urandom;
  endfunction

  always @(posedge clk) begin
    ledger_reply_t want;
    ledger_reply_t got;
    in_taken = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (ledger_replies.size() == 0) begin
          flag_mismatch("unexpected result", 64'({status, found_index, value_after}), '0);
        end else begin
          want = ledger_replies.pop_front();
          if (status !== want.status)
            flag_mismatch("status", 64'(status), 64'(want.status));
          if (found_index !== want.idx)
            flag_mismatch("found_index", 64'(found_index), 64'(want.idx));
          if (value_after !== want.val)
            flag_mismatch("value_after", 64'(value_after), 64'(want.val));
        end
        n_replied++;
      end
      if (in_valid && in_ready) begin
        ledger_apply(cmd, key, amount, got);
        ledger_replies.push_back(got);
        in_taken = 1'b1;
        n_taken++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("timeout after %0d quiet cycles", quiet_cycles);
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

  always @(negedge clk) begin : drive_inputs
    account_cmd_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (account_cmds.size() != 0 && (steady || $urandom_range(99) >= 33) &&
          (!account_cmds[0].after_drain || ledger_replies.size() == 0)) begin
        nxt = account_cmds.pop_front();
        in_valid <= 1'b1;
        cmd <= nxt.cmd;
        key <= nxt.key;
        amount <= nxt.amount;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    int hold_left;
    bit hold_done;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && n_replied >= 100) begin
      hold_done = 1'b1;
      hold_left = HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 33);
    end
  end

  initial begin
    int phase;
    int n_load;
    int n_ops;
    logic [63:0] span;
    logic [63:0] kacc;

    queue_cmd(CMD_READ, '0, '0);
    queue_cmd(CMD_LOAD, '0, '0);
    queue_cmd(CMD_LOAD, 32'd5, VAL_MAX);
    queue_cmd(CMD_LOAD, '1, 47'd100);
    queue_cmd(CMD_ADD, 32'd5, 47'd1);
    queue_cmd(CMD_ADD, '0, VAL_MAX);
    queue_cmd(CMD_SUB, '1, 47'd101);
    queue_cmd(CMD_SUB, '1, 47'd100);
    queue_cmd(CMD_READ, 32'd5, VAL_MAX);
    queue_cmd(CMD_READ, 32'd7, '0);
    queue_cmd(CMD_SUB, 32'd7, 47'd1);
    queue_cmd(CMD_ADD, 32'd6, VAL_MAX);
    queue_cmd(CMD_SPARE_FIRST, $urandom, pick_amount());
    queue_cmd(CMD_W'(CMD_SPARE_FIRST + 1), '1, VAL_MAX);
    queue_cmd(CMD_SPARE_LAST, $urandom, pick_amount());
    queue_cmd(CMD_LOAD, 32'd3, 47'h5555_5555_5555);
    queue_cmd(CMD_LOAD, 32'd5, 47'h2AAA_AAAA_AAAA);
    queue_cmd(CMD_READ, 32'd5, '0);
    queue_cmd(CMD_READ, 32'd3, '0);
    queue_cmd(CMD_SUB, '0, VAL_MAX);
    queue_cmd(CMD_CLEAR, '1, VAL_MAX);
    queue_cmd(CMD_READ, '0, '0);

    phase = 0;
    while (queued_total < RANDOM_ITEMS + 22) begin
      drain_next = (phase % 4 == 3);
      queue_cmd(CMD_CLEAR, $urandom, pick_amount());
      n_load = (phase == 1) ? TABLE_DEPTH + 3 : $urandom_range(24, 1);
      span = 64'hFFFF_FFFF / (n_load + 1);
      kacc = ($urandom_range(3) == 0) ? 64'd0 : 64'($urandom_range(span[31:0]));
      for (int i = 0; i < n_load; i++) begin
        queue_cmd(CMD_LOAD, kacc[31:0], pick_amount());
        kacc = kacc + 64'($urandom_range(span[31:0], 1));
      end
      n_ops = $urandom_range(30, 4);
      for (int i = 0; i < n_ops; i++) begin
        if ($urandom_range(99) < 10) begin
          case ($urandom_range(3))
            0: queue_cmd(CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)),
                         $urandom, pick_amount());
            1: queue_cmd(CMD_LOAD, $urandom, pick_amount());
            2: queue_cmd(CMD_LOAD, pick_key(), pick_amount());
            default: queue_cmd(CMD_CLEAR, $urandom, pick_amount());
          endcase
        end else begin
          case ($urandom_range(2))
            0: queue_cmd(CMD_ADD, pick_key(), pick_amount());
            1: queue_cmd(CMD_SUB, pick_key(), pick_amount());
            default: queue_cmd(CMD_READ, pick_key(), pick_amount());
          endcase
        end
      end
      phase++;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (account_cmds.size() != 0 || in_valid) @(negedge clk);
    while (ledger_replies.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sorted_key_table_balance_update_unit.f
rtl/core/skt_pkg.sv
rtl/core/skt_ram.sv
rtl/core/sorted_key_table_balance_update_unit.sv
dv/tb_sorted_key_table_balance_update_unit.sv
